// ===== rtl/aus_pkg.sv =====
// Package for the Annex-B access unit splitter.
// Holds payload structs, queue record and sizing constants; no dependencies.
`timescale 1ns / 1ps

package aus_pkg;

  // Sizing of the unit byte counter and the reported length field
  localparam int LengthBits = 20;
  localparam int FieldBits  = 20;
  localparam int CmpBits    = (LengthBits > FieldBits) ? LengthBits : FieldBits;

  // Delay line and front/back queue
  localparam int DelayDepth = 5;
  localparam int FillBits   = $clog2(DelayDepth + 1);
  localparam int QueueDepth = 2;
  localparam int QPtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntBits   = $clog2(QueueDepth + 1);

  // Stream constants
  localparam logic [7:0]           NalTypeMask = 8'h1F;
  localparam logic [7:0]           StartByte   = 8'h01;
  localparam logic [FieldBits-1:0] MaxAuReset  = FieldBits'(128 * 1024);
  localparam logic [FieldBits-1:0] Field20Max  = {FieldBits{1'b1}};
  localparam logic [LengthBits-1:0] CountMax   = {LengthBits{1'b1}};

  // One input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_last;
  } au_in_t;

  // One result request
  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 au_last;
    logic                 au_too_long;
    logic [FieldBits-1:0] au_length;
  } au_out_t;

  // Classified byte passed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       mark;
  } aus_rec_t;

endpackage

// ===== rtl/aus_front.sv =====
// Front end: start code and NAL header scan, marks the byte that closes a unit.
// Depends on aus_pkg.
`timescale 1ns / 1ps

module aus_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  aus_pkg::au_in_t in_data_i,
  input  logic            q_full_i,
  output logic            in_stall_o,
  output logic            push_o,
  output aus_pkg::aus_rec_t rec_o
);

  logic [1:0] zero_run_q, zero_run_d;
  logic       expect_hdr_q, expect_hdr_d;
  logic       code_four_q, code_four_d;
  logic       has_slice_q, has_slice_d;
  logic [1:0] countdown_q, countdown_d;

  logic [7:0] b;
  logic [4:0] hdr_kind;
  logic       is_slice;
  logic [1:0] cd_now;

  // chunk_last has no effect on splitting and is dropped here
  assign b          = in_data_i.data_byte;
  assign hdr_kind   = 5'(b & aus_pkg::NalTypeMask);
  assign is_slice   = hdr_kind inside {[5'd1:5'd5]};
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Classify the byte and update scan state
  always_comb begin
    zero_run_d   = zero_run_q;
    expect_hdr_d = expect_hdr_q;
    code_four_d  = code_four_q;
    has_slice_d  = has_slice_q;
    cd_now       = countdown_q;
    if (expect_hdr_q) begin
      if (is_slice && has_slice_q) begin
        cd_now = code_four_q ? 2'd1 : 2'd2;
      end
      if (is_slice) begin
        has_slice_d = 1'b1;
      end
      expect_hdr_d = 1'b0;
    end else if (b == aus_pkg::StartByte && zero_run_q >= 2'd2) begin
      code_four_d  = (zero_run_q == 2'd3);
      expect_hdr_d = 1'b1;
    end
    if (b == 8'd0) begin
      if (zero_run_q != 2'd3) begin
        zero_run_d = zero_run_q + 2'd1;
      end
    end else begin
      zero_run_d = 2'd0;
    end
    countdown_d     = (cd_now != 2'd0) ? cd_now - 2'd1 : 2'd0;
    rec_o.data_byte = b;
    rec_o.mark      = (cd_now == 2'd1);
  end

  // Advance scan state on each pushed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_run_q   <= 2'd0;
      expect_hdr_q <= 1'b0;
      code_four_q  <= 1'b0;
      has_slice_q  <= 1'b0;
      countdown_q  <= 2'd0;
    end else if (push_o) begin
      zero_run_q   <= zero_run_d;
      expect_hdr_q <= expect_hdr_d;
      code_four_q  <= code_four_d;
      has_slice_q  <= has_slice_d;
      countdown_q  <= countdown_d;
    end
  end

endmodule

// ===== rtl/aus_fifo.sv =====
// Short queue between the front scan and the back delay line.
// Depends on aus_pkg.
`timescale 1ns / 1ps

module aus_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  aus_pkg::aus_rec_t push_data_i,
  input  logic              pop_i,
  output aus_pkg::aus_rec_t pop_data_o,
  output logic              full_o,
  output logic              empty_o
);

  aus_pkg::aus_rec_t                 mem_q [aus_pkg::QueueDepth];
  logic [aus_pkg::QPtrBits-1:0]      wr_ptr_q, rd_ptr_q;
  logic [aus_pkg::QCntBits-1:0]      count_q;

  assign full_o     = (count_q == aus_pkg::QCntBits'(aus_pkg::QueueDepth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == aus_pkg::QPtrBits'(aus_pkg::QueueDepth - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == aus_pkg::QPtrBits'(aus_pkg::QueueDepth - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue push while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue pop while empty");

endmodule

// ===== rtl/aus_back.sv =====
// Back end: five-byte delay line, unit length counter and output register.
// Depends on aus_pkg.
`timescale 1ns / 1ps

module aus_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_empty_i,
  input  aus_pkg::aus_rec_t                 rec_i,
  output logic                              pop_o,
  input  logic [aus_pkg::FieldBits-1:0]     max_au_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output aus_pkg::au_out_t                  out_data_o
);

  logic [7:0]                     dline_q [aus_pkg::DelayDepth];
  logic [aus_pkg::FillBits-1:0]   fill_q, fill_d;
  logic [aus_pkg::LengthBits-1:0] cnt_q, cnt_d, cnt_inc;
  logic                           out_valid_q;
  aus_pkg::au_out_t               out_q, out_d;

  logic                           emit;
  logic [aus_pkg::CmpBits-1:0]    cnt_ext, max_ext;

  // Pop whenever the output register is free or being drained
  assign pop_o = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign emit  = (fill_q >= aus_pkg::FillBits'(aus_pkg::DelayDepth));

  assign cnt_inc = (cnt_q == aus_pkg::CountMax) ? cnt_q : cnt_q + 1'b1;
  assign cnt_ext = aus_pkg::CmpBits'(cnt_inc);
  assign max_ext = aus_pkg::CmpBits'(max_au_i);

  // Build the result and the next counter values
  always_comb begin
    fill_d = emit ? fill_q : fill_q + 1'b1;
    cnt_d  = cnt_q;
    out_d.out_byte    = dline_q[aus_pkg::DelayDepth-1];
    out_d.au_last     = rec_i.mark;
    out_d.au_too_long = 1'b0;
    out_d.au_length   = '0;
    if (emit) begin
      cnt_d = cnt_inc;
      if (rec_i.mark) begin
        out_d.au_too_long = (cnt_ext > max_ext);
        out_d.au_length   = (cnt_ext > aus_pkg::CmpBits'(aus_pkg::Field20Max)) ?
                            aus_pkg::Field20Max : cnt_ext[aus_pkg::FieldBits-1:0];
        cnt_d = '0;
      end
    end
  end

  // Shift the delay line
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dline_q[0] <= rec_i.data_byte;
      for (int k = 1; k < aus_pkg::DelayDepth; k++) begin
        dline_q[k] <= dline_q[k-1];
      end
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_q <= out_d;
    end
  end

  // Advance fill, counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        fill_q <= fill_d;
        cnt_q  <= cnt_d;
      end
      if (pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fill_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= aus_pkg::FillBits'(aus_pkg::DelayDepth))
    else $error("delay line fill count out of range");

  a_no_pop_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !pop_o)
    else $error("pop while result is held");

endmodule

// ===== rtl/annexb_access_unit_splitter.sv =====
// Top level of the Annex-B access unit splitter: config register, front, queue, back.
// Depends on aus_pkg, aus_front, aus_fifo and aus_back.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+----------------------------------
//   in      | input     | in_valid_i/stall  | in_data_i  (data_byte, chunk_last)
//   out     | output    | out_valid_o/stall | out_data_o (byte, last, long, len)
//   cfg     | input     | cfg_valid_i/ready | cfg_data_i (max_au_bytes)
//
// One byte is accepted per cycle while in_stall_o is low; results leave at the same
// rate while out_stall_i is low. The result caused by a byte passes through the queue
// and is then held in the output register; the first five bytes only fill
// the delay line and give no result.
// Reset clears the scan state, queue, fill count and length counter; max_au_bytes
// returns to 131072. Input stalls only when the two-entry queue is full, which
// happens when the output is held stalled.
`timescale 1ns / 1ps

module annexb_access_unit_splitter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  aus_pkg::au_in_t               in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output aus_pkg::au_out_t              out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [aus_pkg::FieldBits-1:0] cfg_data_i
);

  logic [aus_pkg::FieldBits-1:0] max_au_q;
  logic                          push, pop, q_full, q_empty;
  aus_pkg::aus_rec_t             push_rec, pop_rec;

  // Take configuration writes at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_au_q <= aus_pkg::MaxAuReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_au_q <= cfg_data_i;
    end
  end

  aus_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  aus_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_rec),
    .pop_i       (pop),
    .pop_data_o  (pop_rec),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  aus_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .rec_i       (pop_rec),
    .pop_o       (pop),
    .max_au_i    (max_au_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_fields_zero_off_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.au_last) |->
      (out_data_o.au_length == '0 && !out_data_o.au_too_long))
    else $error("length or oversize set on a byte that does not end a unit");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for annexb_access_unit_splitter.
// Drives byte streams with random gaps and output stalls, predicts each result in a
// scoreboard class and compares field by field; depends on aus_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 12;
  localparam int PhaseCount   = 12;
  localparam int PhaseBytes   = 145;

  // Tracks the splitter state and holds the results still owed by the block
  class au_split_checker;
    logic [7:0]                     delay_q [aus_pkg::DelayDepth];
    int unsigned                    fill;
    logic [1:0]                     zero_run;
    bit                             hdr_next;
    int unsigned                    code_len;
    bit                             unit_has_slice;
    int unsigned                    close_in;
    logic [aus_pkg::LengthBits-1:0] unit_len;
    logic [aus_pkg::FieldBits-1:0]  max_bytes;
    aus_pkg::au_out_t               owed_results [$];
    int unsigned                    n_errors;
    int unsigned                    n_results;
    int unsigned                    n_units;
    int unsigned                    n_flagged;

    function new();
      for (int k = 0; k < aus_pkg::DelayDepth; k++) delay_q[k] = '0;
      fill           = 0;
      zero_run       = '0;
      hdr_next       = 1'b0;
      code_len       = 0;
      unit_has_slice = 1'b0;
      close_in       = 0;
      unit_len       = '0;
      max_bytes      = aus_pkg::MaxAuReset;
      n_errors       = 0;
      n_results      = 0;
      n_units        = 0;
      n_flagged      = 0;
    endfunction

    function void set_limit(logic [aus_pkg::FieldBits-1:0] v);
      max_bytes = v;
    endfunction

    function int unsigned outstanding();
      return owed_results.size();
    endfunction

    // Advance the scan and the delay line by one accepted byte
    function void take_byte(aus_pkg::au_in_t req);
      logic [7:0]       b;
      logic [7:0]       hdr_kind;
      logic [7:0]       leaving;
      bit               is_slice;
      aus_pkg::au_out_t want;
      b = req.data_byte;
      if (hdr_next) begin
        hdr_kind = b & aus_pkg::NalTypeMask;
        is_slice = (hdr_kind >= 8'd1) && (hdr_kind <= 8'd5);
        // a second slice closes the unit at the first byte of its start code
        if (is_slice && unit_has_slice) close_in = (code_len == 4) ? 1 : 2;
        if (is_slice) unit_has_slice = 1'b1;
        hdr_next = 1'b0;
      end else if (b == aus_pkg::StartByte && zero_run >= 2) begin
        code_len = (zero_run >= 3) ? 4 : 3;
        hdr_next = 1'b1;
      end
      if (b == 8'h00) begin
        if (zero_run < 3) zero_run++;
      end else begin
        zero_run = '0;
      end

      leaving = delay_q[aus_pkg::DelayDepth-1];
      for (int k = aus_pkg::DelayDepth - 1; k > 0; k--) delay_q[k] = delay_q[k-1];
      delay_q[0] = b;
      // no result while the delay line fills
      if (fill < aus_pkg::DelayDepth) begin
        fill++;
        if (close_in != 0) close_in--;
        return;
      end

      if (unit_len != aus_pkg::CountMax) unit_len++;
      want          = '0;
      want.out_byte = leaving;
      if (close_in == 1) begin
        want.au_last     = 1'b1;
        want.au_too_long = (unit_len > max_bytes);
        want.au_length   = (unit_len > aus_pkg::Field20Max) ?
                           aus_pkg::Field20Max : aus_pkg::FieldBits'(unit_len);
        unit_len         = '0;
      end
      if (close_in != 0) close_in--;
      owed_results.push_back(want);
    endfunction

    function void flag_field(string name, int unsigned want, int unsigned seen);
      n_errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, seen);
    endfunction

    // Compare one accepted result with the oldest owed one
    function void match_output(aus_pkg::au_out_t got);
      aus_pkg::au_out_t want;
      if (owed_results.size() == 0) begin
        n_errors++;
        $display("%0t: result with none expected, actual %p", $time, got);
        return;
      end
      want = owed_results.pop_front();
      n_results++;
      if (want.au_last) n_units++;
      if (want.au_too_long) n_flagged++;
      if (got.out_byte !== want.out_byte) flag_field("out_byte", want.out_byte, got.out_byte);
      if (got.au_last !== want.au_last) flag_field("au_last", want.au_last, got.au_last);
      if (got.au_too_long !== want.au_too_long)
        flag_field("au_too_long", want.au_too_long, got.au_too_long);
      if (got.au_length !== want.au_length)
        flag_field("au_length", want.au_length, got.au_length);
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  aus_pkg::au_in_t               in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  aus_pkg::au_out_t              out_data_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [aus_pkg::FieldBits-1:0] cfg_data_i  = '0;

  au_split_checker sb = new();
  int unsigned     cycle_count = 0;
  int unsigned     bytes_sent  = 0;
  int unsigned     limits_used = 0;
  bit              in_calm     = 1'b0;
  bit              out_calm    = 1'b0;

  annexb_access_unit_splitter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("testbench failed");
      $finish;
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.match_output(out_data_o);
  end

  // Stall the output for a random number of cycles before each result
  initial begin : result_sink
    int hold;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
      hold = out_calm ? 0 : $urandom_range(0, 15);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Send one byte after a random gap and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    aus_pkg::au_in_t req;
    int              gap;
    if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.data_byte  = b;
    req.chunk_last = 1'($urandom_range(0, 1));
    in_data_i  <= req;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_byte(req);
    bytes_sent++;
  endtask

  // Drop valid and let every owed result drain
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [aus_pkg::FieldBits-1:0] v);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_limit(v);
    limits_used++;
  endtask

  // One NAL unit: start code, header byte and a short payload
  task automatic send_nal();
    int         zeros;
    int         plen;
    logic [4:0] hdr_kind;
    zeros = $urandom_range(0, 1) ? 2 : 3;
    if ($urandom_range(0, 7) == 0) zeros += $urandom_range(1, 4);
    repeat (zeros) send_byte(8'h00);
    send_byte(aus_pkg::StartByte);
    // mostly slices; otherwise a type from 6..31 or 0 (32 wraps to 0)
    if ($urandom_range(0, 9) < 7) hdr_kind = 5'($urandom_range(1, 5));
    else hdr_kind = 5'($urandom_range(6, 32));
    send_byte({3'($urandom_range(0, 7)), hdr_kind});
    plen = $urandom_range(0, 30);
    repeat (plen) begin
      if ($urandom_range(0, 7) == 0) send_byte(8'h00);
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Stray bytes and broken start codes
  task automatic send_noise();
    int pick;
    repeat ($urandom_range(1, 8)) begin
      pick = $urandom_range(0, 3);
      if (pick == 0) send_byte(8'h00);
      else if (pick == 1) send_byte(aus_pkg::StartByte);
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_random_stream(input int unsigned count);
    int unsigned stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 9) < 8) send_nal();
      else send_noise();
    end
  endtask

  // Leading byte, 3- and 4-byte codes, long zero run, header with high bits,
  // and a zero header feeding the next code, which is the one non-slice header
  task automatic send_opening();
    logic [7:0] seq [$] = '{
      8'h11,
      8'h00, 8'h00, 8'h01, 8'h65, 8'hFF,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hE1,
      8'h00, 8'h00, 8'h01, 8'h00,
      8'h00, 8'h01, 8'hA5, 8'h80,
      8'h00, 8'h00, 8'h00, 8'h01, 8'h43
    };
    foreach (seq[k]) send_byte(seq[k]);
  endtask

  initial begin : stimulus
    logic [aus_pkg::FieldBits-1:0] lim;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_opening();

    // Each phase runs under its own size limit, extremes first
    for (int phase = 0; phase < PhaseCount; phase++) begin
      wait_idle();
      case (phase)
        0: lim = '0;
        1: lim = aus_pkg::FieldBits'(1);
        2: lim = aus_pkg::Field20Max;
        3: lim = aus_pkg::MaxAuReset;
        default: begin
          if ($urandom_range(0, 3) != 0) lim = aus_pkg::FieldBits'($urandom_range(1, 160));
          else lim = aus_pkg::FieldBits'($urandom_range(1, 20'hFFFFF));
        end
      endcase
      write_limit(lim);
      send_random_stream(PhaseBytes);
    end
    wait_idle();

    $display("Sent %0d bytes under %0d size limits; checked %0d results.",
             bytes_sent, limits_used, sb.n_results);
    $display("Closed %0d access units, %0d of them over the limit.",
             sb.n_units, sb.n_flagged);
    if (sb.n_errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
